// ===== design/bbrb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bbrb_pkg
// Shared types and constants for the burst byte ring buffer: item layouts,
// result status codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package bbrb_pkg;

	// default sizing
	localparam int DEPTH_DEF     = 256;
	localparam int MAX_BURST_DEF = 64;
	localparam int CAP_RESET     = 256;
	localparam int CAP_W         = 9;

	// input command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		ST_RD_DATA     = 2'd0,
		ST_RD_REFUSED  = 2'd1,
		ST_WR_ACCEPTED = 2'd2,
		ST_WR_REFUSED  = 2'd3
	} status_t;

	// input item
	typedef struct packed {
		logic       command;
		logic       burst_first;
		logic [6:0] burst_len;
		logic [7:0] data_byte;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [7:0] read_byte;
		status_t    status;
		logic       last;
	} out_item_t;

	// controller states
	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic wr_item;    // take a write item and post its result
		logic rd_start;   // take a read request that can be served
		logic rd_refuse;  // take a read request that cannot be served
		logic rd_issue;   // read one stored byte into the fetch stage
		logic s1_to_out;  // move the fetched byte into the output register
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic read_ok;
		logic rd_rem_zero;
		logic s1_valid;
		logic out_valid;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== design/bbrb_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bbrb_ctrl
// Controller state machine: accepts items while idle, then sequences the
// byte fetches of a counted read until the last byte has left the fetch stage.
// ----------------------------------------------------------------------------
module bbrb_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	input  wire              in_command,
	output logic             in_ready,
	input  wire              out_ready,
	input  bbrb_pkg::dp_stat_t stat,
	output bbrb_pkg::dp_cmd_t  cmd
);
	import bbrb_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   out_free;
	logic   in_acc;

	assign out_free = !stat.out_valid || out_ready;
	assign in_acc   = in_valid && in_ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && (in_command == CMD_READ) && stat.read_ok) begin
					state_nxt = S_READ;
				end
			end
			S_READ: begin
				if (stat.rd_rem_zero && !stat.s1_valid) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready      = out_free;
				cmd.wr_item   = in_acc && (in_command == CMD_WRITE);
				cmd.rd_start  = in_acc && (in_command == CMD_READ) && stat.read_ok;
				cmd.rd_refuse = in_acc && (in_command == CMD_READ) && !stat.read_ok;
			end
			S_READ: begin
				cmd.s1_to_out = stat.s1_valid && out_free;
				cmd.rd_issue  = !stat.rd_rem_zero && (!stat.s1_valid || out_free);
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

`ifndef SYNTHESIS
	// the fetch stage is drained whenever new items are taken
	a_idle_s1_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !stat.s1_valid)
		else $error("fetch stage holds a byte while idle");

	// a served read always enters the read sequence
	a_start_to_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_start |=> (state_q == S_READ))
		else $error("read start did not enter read state");

	// no fetch beyond the requested count
	a_issue_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_issue |-> !stat.rd_rem_zero)
		else $error("byte fetch with no bytes remaining");
`endif

endmodule

`default_nettype wire

// ===== design/bbrb_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bbrb_dp
// Datapath: byte storage, ring pointers, fill count, burst bookkeeping,
// the registered fetch stage for reads and the output register.
// ----------------------------------------------------------------------------
module bbrb_dp #(
	parameter int DEPTH     = bbrb_pkg::DEPTH_DEF,
	parameter int MAX_BURST = bbrb_pkg::MAX_BURST_DEF
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      cfg_wr_en,
	input  wire [bbrb_pkg::CAP_W-1:0] cfg_wr_data,
	input  bbrb_pkg::in_item_t       in_data,
	input  wire                      out_ready,
	input  bbrb_pkg::dp_cmd_t        cmd,
	output bbrb_pkg::dp_stat_t       stat,
	output logic                     out_valid,
	output bbrb_pkg::out_item_t      out_data
);
	import bbrb_pkg::*;

	localparam int PTR_W       = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int RESET_SLOTS = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

	logic [7:0]       mem [DEPTH];

	logic [CNT_W-1:0] slots_q;
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [CNT_W-1:0] fill_q;
	logic [6:0]       brem_q;
	logic             bacc_q;
	logic [6:0]       rd_rem_q;

	logic [7:0]       rdata_s1;
	logic             valid_s1;
	logic             last_s1;

	logic             out_valid_q;
	out_item_t        out_q;

	logic [CNT_W-1:0] cfg_slots;
	logic             len_ok;
	logic             first_acc;
	logic             store;
	logic [CNT_W:0]   wp_inc;
	logic [CNT_W:0]   rp_inc;
	logic [PTR_W-1:0] wp_nxt;
	logic [PTR_W-1:0] rp_nxt;
	logic             wr_good;
	out_item_t        wr_res;

	// capacity clipped into 1..DEPTH
	always_comb begin
		if (cfg_wr_data == '0) begin
			cfg_slots = CNT_W'(1);
		end else if (32'(cfg_wr_data) > 32'(DEPTH)) begin
			cfg_slots = CNT_W'(DEPTH);
		end else begin
			cfg_slots = CNT_W'(cfg_wr_data);
		end
	end

	// length and space checks
	assign len_ok    = (in_data.burst_len != '0) &&
	                   (32'(in_data.burst_len) <= 32'(MAX_BURST));
	assign first_acc = len_ok &&
	                   (32'(in_data.burst_len) <= (32'(slots_q) - 32'(fill_q)));

	// decide what a write item does
	always_comb begin
		if (in_data.burst_first) begin
			wr_good = first_acc;
		end else if (brem_q == '0) begin
			wr_good = 1'b0;
		end else begin
			wr_good = bacc_q && (fill_q < slots_q);
		end
	end
	assign store = cmd.wr_item && wr_good;

	always_comb begin
		wr_res           = '0;
		wr_res.read_byte = '0;
		wr_res.status    = wr_good ? ST_WR_ACCEPTED : ST_WR_REFUSED;
		wr_res.last      = 1'b1;
	end

	// pointer wrap at the capacity in use
	assign wp_inc = (CNT_W + 1)'(wp_q) + (CNT_W + 1)'(1);
	assign rp_inc = (CNT_W + 1)'(rp_q) + (CNT_W + 1)'(1);
	assign wp_nxt = (wp_inc >= (CNT_W + 1)'(slots_q)) ? '0 : wp_inc[PTR_W-1:0];
	assign rp_nxt = (rp_inc >= (CNT_W + 1)'(slots_q)) ? '0 : rp_inc[PTR_W-1:0];

	// ring state and burst bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q  <= CNT_W'(RESET_SLOTS);
			wp_q     <= '0;
			rp_q     <= '0;
			fill_q   <= '0;
			brem_q   <= '0;
			bacc_q   <= 1'b0;
			rd_rem_q <= '0;
		end else if (cfg_wr_en) begin
			slots_q  <= cfg_slots;
			wp_q     <= '0;
			rp_q     <= '0;
			fill_q   <= '0;
			brem_q   <= '0;
			bacc_q   <= 1'b0;
			rd_rem_q <= '0;
		end else begin
			if (cmd.wr_item) begin
				if (in_data.burst_first) begin
					brem_q <= len_ok ? (in_data.burst_len - 7'd1) : '0;
					bacc_q <= first_acc;
				end else if (brem_q == '0) begin
					bacc_q <= 1'b0;
				end else begin
					brem_q <= brem_q - 7'd1;
					if (brem_q == 7'd1) begin
						bacc_q <= 1'b0;
					end
				end
			end
			if (store) begin
				wp_q   <= wp_nxt;
				fill_q <= fill_q + CNT_W'(1);
			end
			if (cmd.rd_start) begin
				rd_rem_q <= in_data.burst_len;
				fill_q   <= fill_q - CNT_W'(in_data.burst_len);
			end
			if (cmd.rd_issue) begin
				rd_rem_q <= rd_rem_q - 7'd1;
				rp_q     <= rp_nxt;
			end
		end
	end

	// byte storage
	always_ff @(posedge clk) begin
		if (store) begin
			mem[wp_q] <= in_data.data_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			rdata_s1 <= mem[rp_q];
			last_s1  <= (rd_rem_q == 7'd1);
		end
	end

	// fetch stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.rd_issue) begin
			valid_s1 <= 1'b1;
		end else if (cmd.s1_to_out) begin
			valid_s1 <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.s1_to_out || cmd.wr_item || cmd.rd_refuse) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		priority if (cmd.s1_to_out) begin
			out_q.read_byte <= rdata_s1;
			out_q.status    <= ST_RD_DATA;
			out_q.last      <= last_s1;
		end else if (cmd.wr_item) begin
			out_q <= wr_res;
		end else if (cmd.rd_refuse) begin
			out_q.read_byte <= '0;
			out_q.status    <= ST_RD_REFUSED;
			out_q.last      <= 1'b1;
		end
	end

	// status back to the controller
	assign stat.read_ok     = len_ok && (32'(in_data.burst_len) <= 32'(fill_q));
	assign stat.rd_rem_zero = (rd_rem_q == '0);
	assign stat.s1_valid    = valid_s1;
	assign stat.out_valid   = out_valid_q;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	// the ring never holds more than its capacity
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= slots_q)
		else $error("fill count above capacity");

	// both pointers stay inside the slots in use
	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((CNT_W + 1)'(wp_q) < (CNT_W + 1)'(slots_q)) &&
		((CNT_W + 1)'(rp_q) < (CNT_W + 1)'(slots_q)))
		else $error("ring pointer outside capacity");

	// a fetch never overwrites a byte that has not moved on
	a_no_s1_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_issue && valid_s1) |-> cmd.s1_to_out)
		else $error("fetch stage overwritten");
`endif

endmodule

`default_nettype wire

// ===== design/burst_byte_ring_buffer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// burst_byte_ring_buffer
// Byte ring buffer with all-or-nothing write bursts and counted reads.
// ----------------------------------------------------------------------------
// Usage:
//  in_valid/in_ready carry one item: a write byte of a burst or a read request.
//  out_valid/out_ready carry results. Each write item gives one result, with
//  status accepted or refused, in the cycle after it is taken; write items
//  can be taken one per cycle while the receiver keeps up.
//  A read request that can be served gives burst_len bytes, oldest first, the
//  last one marked. Each byte is read from storage into the fetch register
//  and then moves into the output register; bytes follow one per cycle
//  while the receiver keeps up. No new item is taken until all bytes of a
//  read have left the fetch stage. A read that cannot be served gives one
//  refusal result.
//  cfg_wr_en/cfg_wr_data set the capacity and empty the ring; write only
//  while idle. Reset empties the ring; capacity becomes min(256, DEPTH).
//  When the receiver stalls, the output register holds its result; the block
//  takes no items and fetches no byte beyond the one in the fetch stage.
// ----------------------------------------------------------------------------
module burst_byte_ring_buffer #(
	parameter int DEPTH     = bbrb_pkg::DEPTH_DEF,
	parameter int MAX_BURST = bbrb_pkg::MAX_BURST_DEF
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cfg_wr_en,
	input  wire [bbrb_pkg::CAP_W-1:0] cfg_wr_data,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  bbrb_pkg::in_item_t        in_data,
	output logic                      out_valid,
	input  wire                       out_ready,
	output bbrb_pkg::out_item_t       out_data
);
	import bbrb_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencing
	bbrb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_command (in_data.command),
		.in_ready   (in_ready),
		.out_ready  (out_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// storage and bookkeeping
	bbrb_dp #(
		.DEPTH     (DEPTH),
		.MAX_BURST (MAX_BURST)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_data     (in_data),
		.out_ready   (out_ready),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_data    (out_data)
	);

endmodule

`default_nettype wire
